// ----- sv/indexed_stack_engine_unit_defines.svh -----
// Assertion macros shared by the stack engine RTL.
// Included by the modules that carry concurrent assertions; depends on nothing.
`ifndef INDEXED_STACK_ENGINE_UNIT_DEFINES_SVH
`define INDEXED_STACK_ENGINE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ISE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ISE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ISE_ASSERT(label, clk, rst_n, prop, msg)
`define ISE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- sv/ise_pkg.sv -----
// Types and constants shared by the stack engine controller, datapath and top level.
// Depends on nothing.
package ise_pkg;

    localparam int MODE_W   = 3;
    localparam int AMT_W    = 7;
    localparam int VAL_W    = 7;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 7;

    // Operation codes carried on the mode input.
    localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    // Read address selection.
    localparam logic [1:0] RA_TOP_K   = 2'd0;
    localparam logic [1:0] RA_BELOW_K = 2'd1;
    localparam logic [1:0] RA_PTR1    = 2'd2;
    localparam logic [1:0] RA_PTR2    = 2'd3;

    // Result value selection.
    localparam logic [1:0] VSEL_ZERO = 2'd0;
    localparam logic [1:0] VSEL_READ = 2'd1;
    localparam logic [1:0] VSEL_HOLD = 2'd2;

    typedef struct packed {
        logic                rd_en;
        logic [1:0]          rd_sel;
        logic                wr_push;
        logic                wr_shift;
        logic                push_init;
        logic                ptr_init;
        logic                hold_load;
        logic                fill_pop;
        logic                fill_dec;
        logic                fill_clr;
        logic                finish;
        logic [1:0]          vsel;
        logic [STATUS_W-1:0] status;
    } ise_cmd_t;

    typedef struct packed {
        logic push_ovf;
        logic pos_bad;
        logic pop_bad;
        logic amt_zero;
        logic pop_empty;
        logic push_last;
        logic shift_none;
        logic shift_last;
    } ise_sts_t;

endpackage

// ----- sv/ise_datapath.sv -----
// Datapath of the stack engine: entry memory, fill count, pointers and result registers.
// Depends on ise_pkg and the assertion macros header.
`include "indexed_stack_engine_unit_defines.svh"

module ise_datapath
    import ise_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [AMT_W-1:0]    amount,
    input  ise_cmd_t            cmd,
    output ise_sts_t            sts,
    output logic [VAL_W-1:0]    value,
    output logic [STATUS_W-1:0] status,
    output logic [FILL_W-1:0]   fill,
    output logic                done
);

    localparam int FW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = ((FW > AMT_W) ? FW : AMT_W) + 1;

    logic [VAL_W-1:0] mem [DEPTH];

    logic [FW-1:0]       fill_reg,   fill_next;
    logic [AW-1:0]       ptr_reg,    ptr_next;
    logic [AMT_W-1:0]    run_reg,    run_next;
    logic [AMT_W-1:0]    amt_reg,    amt_next;
    logic [VAL_W-1:0]    hold_reg,   hold_next;
    logic [VAL_W-1:0]    rd_data_reg;
    logic [VAL_W-1:0]    value_reg,  value_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                done_reg;

    logic [CW-1:0]    fill_w;
    logic [CW-1:0]    amt_w;
    logic [CW-1:0]    top_k_w;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_data;

    assign fill_w  = CW'(fill_reg);
    assign amt_w   = CW'(amount);
    assign top_k_w = fill_w - amt_w;

    always_comb
    begin
        sts.push_ovf   = (fill_w + amt_w) > CW'(DEPTH);
        sts.pos_bad    = (amount == '0) || (amt_w > fill_w);
        sts.pop_bad    = amt_w > fill_w;
        sts.amt_zero   = amount == '0;
        sts.pop_empty  = amt_w == fill_w;
        sts.push_last  = run_reg == amt_reg;
        sts.shift_none = (CW'(ptr_reg) + CW'(1)) == fill_w;
        sts.shift_last = (CW'(ptr_reg) + CW'(2)) == fill_w;
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RA_TOP_K:   rd_addr = AW'(top_k_w);
            RA_BELOW_K: rd_addr = AW'(top_k_w - CW'(1));
            RA_PTR1:    rd_addr = ptr_reg + AW'(1);
            RA_PTR2:    rd_addr = ptr_reg + AW'(2);
            default:    rd_addr = '0;
        endcase
    end

    assign wr_en   = cmd.wr_push || cmd.wr_shift;
    assign wr_addr = cmd.wr_push ? AW'(fill_reg) : ptr_reg;
    assign wr_data = cmd.wr_push ? run_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        fill_next   = fill_reg;
        ptr_next    = ptr_reg;
        run_next    = run_reg;
        amt_next    = amt_reg;
        hold_next   = hold_reg;
        value_next  = value_reg;
        status_next = status_reg;

        if (cmd.fill_clr)
        begin
            fill_next = '0;
        end
        else if (cmd.fill_pop)
        begin
            fill_next = FW'(top_k_w);
        end
        else if (cmd.fill_dec)
        begin
            fill_next = fill_reg - FW'(1);
        end
        else if (cmd.wr_push)
        begin
            fill_next = fill_reg + FW'(1);
        end

        if (cmd.ptr_init)
        begin
            ptr_next = AW'(top_k_w);
        end
        else if (cmd.wr_shift)
        begin
            ptr_next = ptr_reg + AW'(1);
        end

        if (cmd.push_init)
        begin
            run_next = AMT_W'(1);
            amt_next = amount;
        end
        else if (cmd.wr_push)
        begin
            run_next = run_reg + AMT_W'(1);
        end

        if (cmd.hold_load)
        begin
            hold_next = rd_data_reg;
        end

        if (cmd.finish)
        begin
            status_next = cmd.status;
            case (cmd.vsel)
                VSEL_READ: value_next = rd_data_reg;
                VSEL_HOLD: value_next = hold_reg;
                default:   value_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        run_reg    <= run_next;
        amt_reg    <= amt_next;
        hold_reg   <= hold_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign value  = value_reg;
    assign status = status_reg;
    assign fill   = FILL_W'(fill_reg);
    assign done   = done_reg;

    `ISE_ASSERT(a_fill_bound, clk, rst_n, fill_w <= CW'(DEPTH), "fill count above depth")
    `ISE_ASSERT_IMP(a_push_room, clk, rst_n, cmd.wr_push, fill_w < CW'(DEPTH),
        "push write into a full store")
    `ISE_ASSERT_IMP(a_read_below_fill, clk, rst_n, cmd.rd_en, CW'(rd_addr) < fill_w,
        "read of an entry at or above the fill")
    `ISE_ASSERT_IMP(a_shift_below_fill, clk, rst_n, cmd.wr_shift,
        (CW'(ptr_reg) + CW'(1)) < fill_w, "shift write beyond the held entries")

endmodule

// ----- sv/ise_ctrl.sv -----
// Controller of the stack engine: decodes each operation and sequences the datapath.
// Depends on ise_pkg and the assertion macros header.
`include "indexed_stack_engine_unit_defines.svh"

module ise_ctrl
    import ise_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MODE_W-1:0] mode,
    input  ise_sts_t          sts,
    output ise_cmd_t          cmd,
    output logic              busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PUSH  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_REM   = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;

    logic [2:0] state_reg, state_next;

    assign busy = state_reg != S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.vsel   = VSEL_ZERO;
        cmd.status = ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (mode)
                        MODE_PUSH:
                        begin
                            if (sts.push_ovf)
                            begin
                                cmd.finish = 1'b1;
                                cmd.status = ST_OVERFLOW;
                            end
                            else if (sts.amt_zero)
                            begin
                                cmd.finish = 1'b1;
                            end
                            else
                            begin
                                cmd.push_init = 1'b1;
                                state_next    = S_PUSH;
                            end
                        end
                        MODE_PEEK:
                        begin
                            if (sts.pos_bad)
                            begin
                                cmd.finish = 1'b1;
                                cmd.status = ST_RANGE;
                            end
                            else
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = RA_TOP_K;
                                state_next = S_READ;
                            end
                        end
                        MODE_POP:
                        begin
                            if (sts.pop_bad)
                            begin
                                cmd.finish = 1'b1;
                                cmd.status = ST_RANGE;
                            end
                            else
                            begin
                                cmd.fill_pop = 1'b1;
                                if (sts.pop_empty)
                                begin
                                    cmd.finish = 1'b1;
                                end
                                else
                                begin
                                    // The new top sits just below the popped run.
                                    cmd.rd_en  = 1'b1;
                                    cmd.rd_sel = RA_BELOW_K;
                                    state_next = S_READ;
                                end
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (sts.pos_bad)
                            begin
                                cmd.finish = 1'b1;
                                cmd.status = ST_RANGE;
                            end
                            else
                            begin
                                cmd.rd_en    = 1'b1;
                                cmd.rd_sel   = RA_TOP_K;
                                cmd.ptr_init = 1'b1;
                                state_next   = S_REM;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            cmd.fill_clr = 1'b1;
                            cmd.finish   = 1'b1;
                        end
                        default:
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = ST_RANGE;
                        end
                    endcase
                end
            end
            S_PUSH:
            begin
                cmd.wr_push = 1'b1;
                if (sts.push_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.finish = 1'b1;
                cmd.vsel   = VSEL_READ;
                state_next = S_IDLE;
            end
            S_REM:
            begin
                // The removed entry is on the read data now; keep it while the
                // entries above move down, reading one ahead of each write.
                cmd.hold_load = 1'b1;
                if (sts.shift_none)
                begin
                    cmd.fill_dec = 1'b1;
                    cmd.finish   = 1'b1;
                    cmd.vsel     = VSEL_READ;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_PTR1;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.wr_shift = 1'b1;
                if (sts.shift_last)
                begin
                    cmd.fill_dec = 1'b1;
                    cmd.finish   = 1'b1;
                    cmd.vsel     = VSEL_HOLD;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_PTR2;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ISE_ASSERT_IMP(a_busy_ends_with_result, clk, rst_n, $fell(busy), $past(cmd.finish),
        "operation ended without a result")
    `ISE_ASSERT(a_one_fill_change, clk, rst_n,
        $onehot0({cmd.wr_push, cmd.fill_pop, cmd.fill_dec, cmd.fill_clr}),
        "more than one fill update in a cycle")

endmodule

// ----- sv/indexed_stack_engine_unit.sv -----
// Top level of the indexed stack engine: joins the controller and the datapath.
// Depends on ise_pkg, ise_ctrl and ise_datapath.
//
// A LIFO stack of up to DEPTH seven-bit entries with push-run, peek, pop-many,
// remove-inside and clear operations. An operation is taken when start is high
// and busy is low; its single result appears on value, status and fill for one
// cycle with done high, and must be taken then, as the receiver cannot stall.
// A rejected operation, a clear, an empty push or a pop to empty never leaves
// the idle state; a peek or a pop that reports a new top uses the read state;
// a push writes its entries in turn in the push state; a removal at position
// k reads that entry, then moves each entry above it down. The entry memory
// makes one write and one read per cycle. busy is low again in the done cycle,
// so the next operation may be accepted while the result is shown.
module indexed_stack_engine_unit
    import ise_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [MODE_W-1:0]   mode,
    input  logic [AMT_W-1:0]    amount,
    output logic                busy,
    output logic                done,
    output logic [VAL_W-1:0]    value,
    output logic [STATUS_W-1:0] status,
    output logic [FILL_W-1:0]   fill
);

    ise_cmd_t cmd;
    ise_sts_t sts;

    ise_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    ise_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .amount (amount),
        .cmd    (cmd),
        .sts    (sts),
        .value  (value),
        .status (status),
        .fill   (fill),
        .done   (done)
    );

endmodule
